// ===== design/ncdfq_pkg.sv =====
// ----------------------------------------------------------------------------
// ncdfq_pkg
// Types, fixed-point constants and multiply helpers for the normal
// distribution evaluator (cumulative distribution and quantile).
// ----------------------------------------------------------------------------
`default_nettype none

package ncdfq_pkg;

   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] Q48_ONE  = 64'd1 << 48;
   localparam logic [63:0] Q62_ONE  = 64'd1 << 62;

   // pipeline landmarks, quantile lane
   localparam int unsigned Q_MUL  = 1;
   localparam int unsigned Q_NORM = 3;
   localparam int unsigned Q_LOG  = 9;
   localparam int unsigned Q_LN   = 105;
   localparam int unsigned Q_HOR  = 107;
   localparam int unsigned Q_RAD  = 123;
   localparam int unsigned Q_SQ   = 125;
   // pipeline landmarks, distribution lane
   localparam int unsigned C_HOR  = 1;
   localparam int unsigned C_DIV  = 13;
   localparam int unsigned C_SQ   = 76;
   localparam int unsigned C_FIN  = 84;
   localparam int unsigned NUM_STAGES = 182;

   localparam logic [63:0] LN2_Q62 =
      64'((128'd693147180559945309 << 62) / 128'd1000000000000000000);

   localparam logic [63:0] QC0 = 64'((128'd3231081277 << 48) / 128'd1000000000000000000);
   localparam logic [63:0] QC1 = 64'((128'd8360937017 << 48) / 128'd100000000000000000);
   localparam logic [63:0] QC2 = 64'((128'd104527497 << 48) / 128'd100000000000000);
   localparam logic [63:0] QC3 = 64'((128'd5824238515 << 48) / 128'd1000000000000000);
   localparam logic [63:0] QC4 = 64'((128'd6841218299 << 48) / 128'd1000000000000000);
   localparam logic [63:0] QC5 = 64'((128'd2250947176 << 48) / 128'd10000000000000);
   localparam logic [63:0] QC6 = 64'((128'd836435359 << 48) / 128'd1000000000000);
   localparam logic [63:0] QC7 = 64'((128'd3706987906 << 48) / 128'd100000000000);
   localparam logic [63:0] QC8 = 64'((128'd1570796288 << 48) / 128'd1000000000);

   localparam logic [63:0] HC1 = 64'((128'd49867347 << 48) / 128'd1000000000);
   localparam logic [63:0] HC2 = 64'((128'd211410061 << 48) / 128'd10000000000);
   localparam logic [63:0] HC3 = 64'((128'd32776263 << 48) / 128'd10000000000);
   localparam logic [63:0] HC4 = 64'((128'd380036 << 48) / 128'd10000000000);
   localparam logic [63:0] HC5 = 64'((128'd488906 << 48) / 128'd10000000000);
   localparam logic [63:0] HC6 = 64'((128'd5383 << 48) / 128'd1000000000);

   typedef struct packed {
      logic              mode;
      logic              err;
      logic              half;
      logic              qneg;
      logic              tail;
      logic              pos;
      logic [6:0]        e;
      logic [47:0]       l2;
      logic [63:0]       x;
      logic [63:0]       w;
      logic signed [63:0] acc;
      logic              sgn;
      logic [3:0][63:0]  qpp;
      logic [111:0]      nrad;
      logic [59:0]       rem;
      logic [55:0]       root;
      logic [63:0]       t;
      logic [63:0]       p;
      logic [63:0]       cq;
      logic [63:0]       drem;
      logic [63:0]       cres;
      logic [3:0][63:0]  cpp;
      logic [63:0]       res;
      logic              rerr;
   } rec_type;

   // quantile polynomial, highest power first, signed Q48
   function automatic logic signed [63:0] quant_coef(input logic [3:0] idx);
      logic signed [63:0] c;
      case (idx)
         4'd0:    c = -$signed(QC0);
         4'd1:    c = $signed(QC1);
         4'd2:    c = -$signed(QC2);
         4'd3:    c = $signed(QC3);
         4'd4:    c = $signed(QC4);
         4'd5:    c = -$signed(QC5);
         4'd6:    c = -$signed(QC6);
         4'd7:    c = $signed(QC7);
         4'd8:    c = $signed(QC8);
         default: c = '0;
      endcase
      return c;
   endfunction

   // hastings polynomial from d6 down, then the constant one
   function automatic logic [63:0] hast_coef(input logic [2:0] idx);
      logic [63:0] c;
      case (idx)
         3'd0:    c = HC6;
         3'd1:    c = HC5;
         3'd2:    c = HC4;
         3'd3:    c = HC3;
         3'd4:    c = HC2;
         3'd5:    c = HC1;
         3'd6:    c = Q48_ONE;
         default: c = '0;
      endcase
      return c;
   endfunction

   // four 32x32 partial products of a 64x64 product
   function automatic logic [3:0][63:0] parts(input logic [63:0] a, input logic [63:0] b);
      logic [3:0][63:0] pp;
      pp[3] = 64'(a[63:32]) * 64'(b[63:32]);
      pp[2] = 64'(a[63:32]) * 64'(b[31:0]);
      pp[1] = 64'(a[31:0]) * 64'(b[63:32]);
      pp[0] = 64'(a[31:0]) * 64'(b[31:0]);
      return pp;
   endfunction

   function automatic logic [127:0] psum(input logic [3:0][63:0] pp);
      return (128'(pp[3]) << 64) + (128'(pp[2]) << 32) + (128'(pp[1]) << 32)
             + 128'(pp[0]);
   endfunction

   // right shift of a product, saturating to all ones
   function automatic logic [63:0] shr_sat(input logic [127:0] prod, input int unsigned s);
      logic [127:0] v;
      v = prod >> s;
      return (v[127:64] != 64'd0) ? ALL_ONES : v[63:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/normal_cdf_and_quantile.sv =====
// ----------------------------------------------------------------------------
// normal_cdf_and_quantile
// Standard normal cumulative distribution (mode 1) and quantile (mode 0)
// in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// depth from accepted item to result is set by the quantile lane
// (48 log2 squarings, two-stage split multiplies, 56-step square root)
// throughput: one item per cycle; a stalled result holds the whole pipeline
// reset clears the stage valid bits only
`default_nettype none

module normal_cdf_and_quantile #(
   parameter int unsigned VALUE_WIDTH = 48,
   parameter int unsigned FRAC_BITS   = 40
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_mode,
   input  wire  signed [VALUE_WIDTH-1:0] req_arg_value,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_value,
   output logic                          rsp_range_error
);

   localparam int unsigned NS = ncdfq_pkg::NUM_STAGES;
   localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
   localparam logic [63:0] HALF  = ONE >> 1;
   localparam logic [63:0] SEVEN = ONE * 64'd7;
   localparam logic [63:0] LIM   = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam int QSH  = int'(FRAC_BITS) - 48;
   localparam int unsigned Q_SL = (QSH >= 0) ? QSH : 0;
   localparam int unsigned Q_SR = (QSH >= 0) ? 0 : -QSH;
   localparam int unsigned C_SR = 62 - FRAC_BITS;
   localparam int unsigned T_SR = (QSH >= 0) ? QSH : 0;
   localparam int unsigned T_SL = (QSH >= 0) ? 0 : -QSH;

   function automatic logic [63:0] encode_word(input logic [63:0] mag_in, input logic neg,
                                               input int unsigned sl, input int unsigned sr);
      logic [63:0] v;
      v = mag_in >> sr;
      if (v > (ncdfq_pkg::ALL_ONES >> sl)) v = ncdfq_pkg::ALL_ONES;
      else v = v << sl;
      if (v > LIM) v = LIM;
      if (neg) v = -v;
      return v;
   endfunction

   ncdfq_pkg::rec_type st_ff [NS];
   ncdfq_pkg::rec_type st_in [NS];
   logic [NS-1:0]      vld_ff;
   logic               adv;

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !adv;

   // decode of the accepted item
   always_comb begin
      ncdfq_pkg::rec_type n;
      logic               neg;
      logic [64:0]        raw_ext;
      logic [63:0]        mag;
      logic [63:0]        qv;
      neg     = req_arg_value[VALUE_WIDTH-1];
      raw_ext = 65'(req_arg_value);
      mag     = neg ? 64'(-$signed(raw_ext)) : raw_ext[63:0];
      n       = '0;
      n.mode  = req_mode;
      n.err   = neg || (mag == 64'd0) || (mag >= ONE);
      n.half  = (mag == HALF);
      n.qneg  = (mag < HALF);
      qv      = n.qneg ? mag : (ONE - mag);
      n.x     = qv << (62 - FRAC_BITS);
      n.tail  = (mag > SEVEN);
      n.pos   = !neg && (mag != 64'd0);
      n.t     = (mag >> T_SR) << T_SL;
      n.p     = ncdfq_pkg::hast_coef(3'd0);
      st_in[0] = n;
   end

   for (genvar k = 1; k < NS; k++) begin : g_stage
      localparam int unsigned QN = (k >= ncdfq_pkg::Q_NORM && k < ncdfq_pkg::Q_NORM + 6)
                                   ? k - ncdfq_pkg::Q_NORM : 0;
      localparam int unsigned SH = 32 >> QN;
      localparam int unsigned LJ = (k >= ncdfq_pkg::Q_LOG && k < ncdfq_pkg::Q_LOG + 96)
                                   ? (k - ncdfq_pkg::Q_LOG) / 2 : 0;
      localparam int unsigned HJ = (k >= ncdfq_pkg::Q_HOR && k < ncdfq_pkg::Q_HOR + 16)
                                   ? (k - ncdfq_pkg::Q_HOR) / 2 + 1 : 1;
      localparam int unsigned CJ = (k >= ncdfq_pkg::C_HOR && k < ncdfq_pkg::C_HOR + 12)
                                   ? (k - ncdfq_pkg::C_HOR) / 2 + 1 : 1;

      always_comb begin
         ncdfq_pkg::rec_type n;
         logic [127:0] qprod;
         logic [127:0] cprod;
         logic [63:0]  m;
         logic [63:0]  sq;
         logic [63:0]  cv;
         logic [59:0]  rsh;
         logic [57:0]  trial;
         logic [64:0]  dr;
         n     = st_ff[k-1];
         qprod = ncdfq_pkg::psum(n.qpp);
         cprod = ncdfq_pkg::psum(n.cpp);
         m     = ncdfq_pkg::shr_sat(qprod, 48);
         if (m > ncdfq_pkg::Q62_ONE) m = ncdfq_pkg::Q62_ONE;
         sq    = qprod[125:62];
         rsh   = {n.rem[57:0], n.nrad[111:110]};
         trial = {n.root, 2'b01};
         dr    = {n.drem, 1'b0};
         cv    = '0;

         // quantile lane: log argument, normalize, log2, w, horner, root
         if (k == ncdfq_pkg::Q_MUL) begin
            n.qpp = ncdfq_pkg::parts(n.x, ncdfq_pkg::Q62_ONE - n.x);
         end else if (k == ncdfq_pkg::Q_MUL + 1) begin
            n.x = {qprod[123:62], 2'b00};
            if (n.x == 64'd0) n.x = 64'd1;
         end else if (k >= ncdfq_pkg::Q_NORM && k < ncdfq_pkg::Q_NORM + 6) begin
            if ((n.x[62:0] >> (63 - SH)) == 63'd0) begin
               n.x = n.x << SH;
               n.e = n.e + 7'(SH);
            end
         end else if (k >= ncdfq_pkg::Q_LOG && k < ncdfq_pkg::Q_LOG + 96) begin
            if (((k - ncdfq_pkg::Q_LOG) % 2) == 0) begin
               n.qpp = ncdfq_pkg::parts(n.x, n.x);
            end else if (sq[63]) begin
               n.x = {1'b0, sq[63:1]};
               n.l2[47-LJ] = 1'b1;
            end else begin
               n.x = sq;
            end
         end else if (k == ncdfq_pkg::Q_LN) begin
            n.qpp = ncdfq_pkg::parts((64'(n.e) << 48) - 64'(n.l2), ncdfq_pkg::LN2_Q62);
         end else if (k == ncdfq_pkg::Q_LN + 1) begin
            n.w   = ncdfq_pkg::shr_sat(qprod, 62);
            n.acc = ncdfq_pkg::quant_coef(4'd0);
         end else if ((k >= ncdfq_pkg::Q_HOR && k < ncdfq_pkg::Q_HOR + 16)
                      || k == ncdfq_pkg::Q_RAD) begin
            if (((k - ncdfq_pkg::Q_HOR) % 2) == 0) begin
               n.sgn = n.acc[63];
               n.qpp = ncdfq_pkg::parts(n.acc[63] ? 64'(-n.acc) : 64'(n.acc), n.w);
            end else begin
               n.acc = (n.sgn ? -$signed(m) : $signed(m)) + ncdfq_pkg::quant_coef(4'(HJ));
            end
         end else if (k == ncdfq_pkg::Q_RAD + 1) begin
            n.nrad = (!n.sgn && m != 64'd0) ? {m, 48'd0} : 112'd0;
            n.rem  = '0;
            n.root = '0;
         end else if (k >= ncdfq_pkg::Q_SQ && k < ncdfq_pkg::Q_SQ + 56) begin
            if (rsh >= 60'(trial)) begin
               n.rem  = rsh - 60'(trial);
               n.root = {n.root[54:0], 1'b1};
            end else begin
               n.rem  = rsh;
               n.root = {n.root[54:0], 1'b0};
            end
            n.nrad = n.nrad << 2;
         end

         // distribution lane: horner, reciprocal, four squarings, mirror
         if (k >= ncdfq_pkg::C_HOR && k < ncdfq_pkg::C_HOR + 12) begin
            if (((k - ncdfq_pkg::C_HOR) % 2) == 0) begin
               n.cpp = ncdfq_pkg::parts(n.t, n.p);
            end else begin
               n.p = ncdfq_pkg::hast_coef(3'(CJ)) + ncdfq_pkg::shr_sat(cprod, 48);
            end
         end else if (k == ncdfq_pkg::C_DIV) begin
            // p is at least one, so the integer quotient is 0 or 1
            n.cq   = (n.p == ncdfq_pkg::Q48_ONE) ? 64'd1 : 64'd0;
            n.drem = ncdfq_pkg::Q48_ONE - ((n.p == ncdfq_pkg::Q48_ONE) ? n.p : 64'd0);
         end else if (k > ncdfq_pkg::C_DIV && k <= ncdfq_pkg::C_DIV + 62) begin
            if (dr >= 65'(n.p)) begin
               n.drem = 64'(dr - 65'(n.p));
               n.cq   = {n.cq[62:0], 1'b1};
            end else begin
               n.drem = dr[63:0];
               n.cq   = {n.cq[62:0], 1'b0};
            end
         end else if (k >= ncdfq_pkg::C_SQ && k < ncdfq_pkg::C_SQ + 8) begin
            if (((k - ncdfq_pkg::C_SQ) % 2) == 0) begin
               n.cpp = ncdfq_pkg::parts(n.cq, n.cq);
            end else begin
               n.cq = ncdfq_pkg::shr_sat(cprod, 62);
            end
         end else if (k == ncdfq_pkg::C_FIN) begin
            if (n.tail) cv = n.pos ? ncdfq_pkg::Q62_ONE : 64'd0;
            else if (n.pos) cv = ncdfq_pkg::Q62_ONE - (n.cq >> 1);
            else cv = n.cq >> 1;
            n.cres = encode_word(cv, 1'b0, 0, C_SR);
         end

         // result selection
         if (k == NS - 1) begin
            if (n.mode) begin
               n.res  = n.cres;
               n.rerr = 1'b0;
            end else begin
               n.res  = (n.err || n.half) ? 64'd0
                        : encode_word(64'(n.root), n.qneg, Q_SL, Q_SR);
               n.rerr = n.err;
            end
         end
         st_in[k] = n;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   assign rsp_valid       = vld_ff[NS-1];
   assign rsp_res_value   = $signed(st_ff[NS-1].res[VALUE_WIDTH-1:0]);
   assign rsp_range_error = st_ff[NS-1].rerr;

endmodule

`default_nettype wire
